FILE: design/quaternion_to_euler_angles_assert.svh
// Assertion macros for the quaternion to Euler angles block.
// Included by the top level; uses the clk and rst_n names of the including module.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// The condition must never hold outside reset.
`define QTE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/qte_pkg.sv
// Shared types, widths and constants of the quaternion to Euler angles block.
// No dependencies; used by every module of the block.
`default_nettype none
package qte_pkg;

  localparam int QW = 16;   // quaternion component width
  localparam int PW = 34;   // width of the atan2 operands
  localparam int RW = 33;   // width of a clamped square root argument
  localparam int CW = 36;   // CORDIC datapath width
  localparam int AW = 34;   // binary angle width after unwrapping
  localparam int SQ_BITS = 25; // result bits of one square root
  localparam int TAB_LEN = 24;

  localparam logic signed [AW-1:0] BA_QUARTER = 34'sd1073741824;
  localparam logic signed [AW-1:0] BA_HALF    = 34'sd2147483648;
  localparam logic signed [AW-1:0] BA_TURN    = 34'sd4294967296;

  // pi * 2^29 split into a high and a low 16-bit half.
  localparam logic signed [16:0] PI_HI = 17'sd25735;
  localparam logic signed [16:0] PI_LO = 17'sd60753;

  typedef struct packed {
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] yy;
    logic signed [PW-1:0] yx;
    logic [RW-1:0]        arg_a;
    logic [RW-1:0]        arg_b;
  } job_t;

  // atan(2^-k) as a binary angle, one full turn is 2^32.
  function automatic logic [31:0] atan_ba(input int k);
    logic [31:0] v;
    v = 32'd0;
    case (k)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: design/qte_front.sv
// Front part: accepts a quaternion, forms all products and the atan2 and root operands.
// Depends on qte_pkg.
`default_nettype none
module qte_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [qte_pkg::QW-1:0] qi,
  input  wire logic signed [qte_pkg::QW-1:0] qj,
  input  wire logic signed [qte_pkg::QW-1:0] qk,
  input  wire logic signed [qte_pkg::QW-1:0] qr,
  output logic                            job_valid,
  input  wire logic                       job_ready,
  output qte_pkg::job_t                   job
);
  import qte_pkg::*;

  logic s1_vld_r, s2_vld_r, s1_adv, s2_adv;
  logic signed [31:0] p_ri_r, p_jk_r, p_ii_r, p_jj_r, p_rj_r, p_ik_r, p_rk_r, p_ij_r, p_kk_r;
  job_t job_r, job_nxt;
  logic signed [PW-1:0] s_diff;
  logic signed [PW:0]   a_full, b_full;

  assign s2_adv   = !s2_vld_r || job_ready;
  assign s1_adv   = !s1_vld_r || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_r <= in_valid;
      if (s2_adv) s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      p_ri_r <= qr * qi;
      p_jk_r <= qj * qk;
      p_ii_r <= qi * qi;
      p_jj_r <= qj * qj;
      p_rj_r <= qr * qj;
      p_ik_r <= qi * qk;
      p_rk_r <= qr * qk;
      p_ij_r <= qi * qj;
      p_kk_r <= qk * qk;
    end
    if (s2_adv) job_r <= job_nxt;
  end

  always_comb begin
    job_nxt.py = (PW'(p_ri_r) + PW'(p_jk_r)) <<< 1;
    job_nxt.px = (PW'(1) <<< 28) - ((PW'(p_ii_r) + PW'(p_jj_r)) <<< 1);
    job_nxt.yy = (PW'(p_rk_r) + PW'(p_ij_r)) <<< 1;
    job_nxt.yx = (PW'(1) <<< 28) - ((PW'(p_jj_r) + PW'(p_kk_r)) <<< 1);
    s_diff = PW'(p_rj_r) - PW'(p_ik_r);
    a_full = ((PW+1)'(1) <<< 28) + ((PW+1)'(s_diff) <<< 1);
    b_full = ((PW+1)'(1) <<< 28) - ((PW+1)'(s_diff) <<< 1);
    // Negative root arguments clamp to zero.
    job_nxt.arg_a = a_full[PW] ? '0 : a_full[RW-1:0];
    job_nxt.arg_b = b_full[PW] ? '0 : b_full[RW-1:0];
  end

  assign job_valid = s2_vld_r;
  assign job       = job_r;

endmodule
`default_nettype wire

FILE: design/qte_fifo.sv
// Four-entry queue of decoded jobs between the front and back parts.
// Depends on qte_pkg.
`default_nettype none
module qte_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qte_pkg::job_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qte_pkg::job_t      out_data
);
  import qte_pkg::*;

  localparam int DEPTH = 4;

  job_t mem_r [DEPTH];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic push, pop;

  assign in_ready  = (cnt_r != 3'(DEPTH));
  assign out_valid = (cnt_r != 3'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 2'd1;
      if (push && !pop)      cnt_r <= cnt_r + 3'd1;
      else if (pop && !push) cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_data;
  end

endmodule
`default_nettype wire

FILE: design/qte_cordic.sv
// One pipelined vectoring CORDIC lane: atan2(y, x) as an unwrapped binary angle.
// Depends on qte_pkg.
`default_nettype none
module qte_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [qte_pkg::CW-1:0] y_in,
  input  wire logic signed [qte_pkg::CW-1:0] x_in,
  output logic signed [qte_pkg::AW-1:0]      ang
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_r [STAGES+1];
  logic signed [CW-1:0] y_r [STAGES+1];
  logic [31:0]          acc_r [STAGES+1];
  logic                 zero_r [STAGES+1];
  logic                 yneg_r [STAGES+1];

  // Quadrant prerotation so that x is not negative.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      yneg_r[0] <= y_in[CW-1];
      if (x_in[CW-1]) begin
        if (!y_in[CW-1]) begin
          x_r[0]   <= y_in;
          y_r[0]   <= -x_in;
          acc_r[0] <= 32'h4000_0000;
        end else begin
          x_r[0]   <= -y_in;
          y_r[0]   <= x_in;
          acc_r[0] <= 32'hC000_0000;
        end
      end else begin
        x_r[0]   <= x_in;
        y_r[0]   <= y_in;
        acc_r[0] <= 32'd0;
      end
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[k+1] <= zero_r[k];
        yneg_r[k+1] <= yneg_r[k];
        if (y_r[k] > 0) begin
          x_r[k+1]   <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1]   <= y_r[k] - (x_r[k] >>> k);
          acc_r[k+1] <= acc_r[k] + atan_ba(k);
        end else begin
          x_r[k+1]   <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1]   <= y_r[k] + (x_r[k] >>> k);
          acc_r[k+1] <= acc_r[k] - atan_ba(k);
        end
      end
    end
  end

  // Unwrap the angle to the half plane of the original y.
  always_comb begin
    ang = AW'($signed(acc_r[STAGES]));
    if (!yneg_r[STAGES] && ang < -BA_QUARTER) ang = ang + BA_TURN;
    if (yneg_r[STAGES] && ang > BA_QUARTER)   ang = ang - BA_TURN;
    if (zero_r[STAGES]) ang = '0;
  end

endmodule
`default_nettype wire

FILE: design/qte_back.sv
// Back part: square roots, three CORDIC lanes, clamping and radian scaling.
// Depends on qte_pkg and qte_cordic.
`default_nettype none
module qte_back #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire qte_pkg::job_t job,
  output logic               res_valid,
  input  wire logic          res_ready,
  output logic [15:0]        pitch_angle,
  output logic [14:0]        roll_angle,
  output logic [15:0]        yaw_angle
);
  import qte_pkg::*;

  localparam int NSQ = SQ_BITS + 1;            // root stages incl. load
  localparam int LEN = NSQ + CORDIC_STAGES + 4; // all valid stages
  localparam int SH  = 60 - ANGLE_FRAC_BITS;
  localparam int RMW = 2 * SQ_BITS + 1;        // remainder width

  logic adv;
  logic [LEN-1:0] vld_r;

  logic [RMW-1:0]     ra_r [NSQ];
  logic [RMW-1:0]     rb_r [NSQ];
  logic [SQ_BITS-1:0] qa_r [NSQ];
  logic [SQ_BITS-1:0] qb_r [NSQ];
  logic signed [PW-1:0] py_r [NSQ];
  logic signed [PW-1:0] px_r [NSQ];
  logic signed [PW-1:0] yy_r [NSQ];
  logic signed [PW-1:0] yx_r [NSQ];

  logic signed [AW-1:0] ang_p, ang_r, ang_y, roll_c;
  logic signed [AW-1:0] ba_r [3];
  logic signed [49:0]   hi_r [3];
  logic signed [50:0]   lo_r [3];
  logic signed [63:0]   scaled [3];
  logic [15:0] pitch_r, yaw_r;
  logic [14:0] roll_r;

  assign adv       = !vld_r[LEN-1] || res_ready;
  assign job_ready = adv;
  assign res_valid = vld_r[LEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LEN-2:0], job_valid};
  end

  // Load stage of the restoring square roots.
  always_ff @(posedge clk) begin
    if (adv) begin
      ra_r[0] <= RMW'({job.arg_a, 16'd0});
      rb_r[0] <= RMW'({job.arg_b, 16'd0});
      qa_r[0] <= '0;
      qb_r[0] <= '0;
      py_r[0] <= job.py;
      px_r[0] <= job.px;
      yy_r[0] <= job.yy;
      yx_r[0] <= job.yx;
    end
  end

  // One result bit per stage, most significant first.
  for (genvar n = 0; n < SQ_BITS; n++) begin : g_sqrt
    localparam int P = SQ_BITS - 1 - n;
    logic [RMW-1:0] trial_a, trial_b;
    assign trial_a = (RMW'(qa_r[n]) << (P + 1)) + (RMW'(1) << (2 * P));
    assign trial_b = (RMW'(qb_r[n]) << (P + 1)) + (RMW'(1) << (2 * P));
    always_ff @(posedge clk) begin
      if (adv) begin
        py_r[n+1] <= py_r[n];
        px_r[n+1] <= px_r[n];
        yy_r[n+1] <= yy_r[n];
        yx_r[n+1] <= yx_r[n];
        if (ra_r[n] >= trial_a) begin
          ra_r[n+1] <= ra_r[n] - trial_a;
          qa_r[n+1] <= qa_r[n] | (SQ_BITS'(1) << P);
        end else begin
          ra_r[n+1] <= ra_r[n];
          qa_r[n+1] <= qa_r[n];
        end
        if (rb_r[n] >= trial_b) begin
          rb_r[n+1] <= rb_r[n] - trial_b;
          qb_r[n+1] <= qb_r[n] | (SQ_BITS'(1) << P);
        end else begin
          rb_r[n+1] <= rb_r[n];
          qb_r[n+1] <= qb_r[n];
        end
      end
    end
  end

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk (clk), .en (adv),
    .y_in (CW'(py_r[NSQ-1])), .x_in (CW'(px_r[NSQ-1])), .ang (ang_p)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk (clk), .en (adv),
    .y_in (CW'(qa_r[NSQ-1])), .x_in (CW'(qb_r[NSQ-1])), .ang (ang_r)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk (clk), .en (adv),
    .y_in (CW'(yy_r[NSQ-1])), .x_in (CW'(yx_r[NSQ-1])), .ang (ang_y)
  );

  always_comb begin
    roll_c = ang_r;
    if (roll_c < 0) roll_c = '0;
    if (roll_c > BA_QUARTER) roll_c = BA_QUARTER;
    roll_c = (roll_c <<< 1) - BA_QUARTER;
  end

  for (genvar m = 0; m < 3; m++) begin : g_scale
    assign scaled[m] = ((64'(hi_r[m]) <<< 16) + 64'(lo_r[m]) + (64'sd1 <<< (SH - 1))) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ba_r[0] <= (ang_p > BA_HALF) ? BA_HALF : ((ang_p < -BA_HALF) ? -BA_HALF : ang_p);
      ba_r[1] <= roll_c;
      ba_r[2] <= (ang_y > BA_HALF) ? BA_HALF : ((ang_y < -BA_HALF) ? -BA_HALF : ang_y);
      for (int m = 0; m < 3; m++) begin
        hi_r[m] <= ba_r[m] * PI_HI;
        lo_r[m] <= ba_r[m] * PI_LO;
      end
      pitch_r <= scaled[0][15:0];
      roll_r  <= scaled[1][14:0];
      yaw_r   <= scaled[2][15:0];
    end
  end

  assign pitch_angle = pitch_r;
  assign roll_angle  = roll_r;
  assign yaw_angle   = yaw_r;

endmodule
`default_nettype wire

FILE: design/quaternion_to_euler_angles.sv
// Top level of the quaternion to Euler angles converter.
// Depends on qte_pkg, qte_front, qte_fifo, qte_back and the assertion header.
`default_nettype none
// Converts one orientation quaternion (i, j, k, real as signed Q14) per beat into
// pitch, roll and yaw in radians with ANGLE_FRAC_BITS fraction bits, in ZYX order.
// Pitch and yaw come from a vectoring CORDIC atan2; roll is twice the atan2 of two
// square roots minus pi/2, with negative root arguments clamped to zero. Inputs are
// not normalized. The block takes a new quaternion every cycle while the result side
// keeps up: the front multiplies and forms the operands, a four-entry queue follows,
// and the back is a fully pipelined chain of 25 square root bit stages, the
// CORDIC_STAGES rotation stages and three scaling stages. Back-pressure on the result
// side stalls the back; the queue lets the front keep taking beats until it fills.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] quat_i, [31:16] quat_j, [47:32] quat_k, [63:48] quat_real
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] pitch_angle, [30:16] roll_angle, [46:31] yaw_angle, [47] zero
  output logic [47:0]      out_tdata
);
  import qte_pkg::*;

  job_t front_job, fifo_job;
  logic front_valid, fifo_in_ready, fifo_out_valid, back_ready;
  logic [15:0] pitch_angle, yaw_angle;
  logic [14:0] roll_angle;

  qte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .qi        ($signed(in_tdata[15:0])),
    .qj        ($signed(in_tdata[31:16])),
    .qk        ($signed(in_tdata[47:32])),
    .qr        ($signed(in_tdata[63:48])),
    .job_valid (front_valid),
    .job_ready (fifo_in_ready),
    .job       (front_job)
  );

  qte_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (fifo_in_ready),
    .in_data   (front_job),
    .out_valid (fifo_out_valid),
    .out_ready (back_ready),
    .out_data  (fifo_job)
  );

  qte_back #(
    .CORDIC_STAGES   (CORDIC_STAGES),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (fifo_out_valid),
    .job_ready   (back_ready),
    .job         (fifo_job),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle),
    .yaw_angle   (yaw_angle)
  );

  assign out_tdata = {1'b0, yaw_angle, roll_angle, pitch_angle};

`include "quaternion_to_euler_angles_assert.svh"

  // A result beat that is held off stays offered and unchanged.
  `QTE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat dropped or changed while stalled")
  // Reset empties the result stage.
  `QTE_ASSERT_NEXT(a_reset_clears, !rst_n, !out_tvalid, "result valid right after reset")

endmodule
`default_nettype wire

FILE: test/tb_quaternion_to_euler_angles.sv
// Testbench for the quaternion to Euler angles converter: drives quaternion beats,
// predicts each angle triple with its own fixed-point CORDIC model and checks results.
// Depends on qte_pkg and the quaternion_to_euler_angles top level.
`default_nettype none
module tb_quaternion_to_euler_angles;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 16;
  localparam int FRAC = 13;
  localparam longint PI_SCALED = 64'sd1686629713;  // pi * 2^29
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint QUARTER_TURN = 64'sd1073741824;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [63:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [47:0] out_tdata;

  quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES), .ANGLE_FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  logic [63:0] pending_quats[$];
  logic [47:0] expected_angles[$];
  int errors = 0;
  bit quiet_phase = 0;  // no idling on either side near the end
  bit hold_start = 0;   // requests the long receiver stall
  bit hold_off = 0;     // long receiver stall, timed by its own process

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Arithmetic shift right that floors, as in the angle datapath.
  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, bit_val;
    res = 0;
    bit_val = 64'sd1 <<< 62;
    while (bit_val > v) bit_val = bit_val >>> 2;
    while (bit_val != 0) begin
      if (v >= res + bit_val) begin
        v = v - (res + bit_val);
        res = (res >>> 1) + bit_val;
      end else begin
        res = res >>> 1;
      end
      bit_val = bit_val >>> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC atan2; binary angle with 2^32 per turn.
  function automatic longint atan2_angle(longint y, longint x);
    longint y0, t, dx, dy, s;
    logic [31:0] acc;
    y0 = y;
    acc = 32'd0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 32'h4000_0000;
      end else begin
        x = -y; y = t; acc = 32'hC000_0000;
      end
    end
    for (int k = 0; k < STAGES && k < qte_pkg::TAB_LEN; k++) begin
      dx = floor_shift(x, k);
      dy = floor_shift(y, k);
      if (y > 0) begin
        x = x + dy; y = y - dx; acc = acc + qte_pkg::atan_ba(k);
      end else begin
        x = x - dy; y = y + dx; acc = acc - qte_pkg::atan_ba(k);
      end
    end
    s = longint'({32'd0, acc});
    if (s >= HALF_TURN) s = s - 2 * HALF_TURN;
    if (y0 >= 0 && s < -QUARTER_TURN) s = s + 2 * HALF_TURN;
    if (y0 < 0 && s > QUARTER_TURN) s = s - 2 * HALF_TURN;
    return s;
  endfunction

  function automatic longint angle_to_radians(longint ba, longint lim);
    int sh;
    sh = 60 - FRAC;
    if (ba > lim) ba = lim;
    if (ba < -lim) ba = -lim;
    return floor_shift(ba * PI_SCALED + (64'sd1 <<< (sh - 1)), sh);
  endfunction

  function automatic logic [47:0] euler_from_quat(logic [63:0] q);
    longint qi, qj, qk, qr, one, s, a, b, r, pitch, roll, yaw;
    logic [47:0] res;
    qi = longint'($signed(q[15:0]));
    qj = longint'($signed(q[31:16]));
    qk = longint'($signed(q[47:32]));
    qr = longint'($signed(q[63:48]));
    one = 64'sd1 <<< 28;
    pitch = angle_to_radians(atan2_angle(2 * (qr * qi + qj * qk),
                                         one - 2 * (qi * qi + qj * qj)), HALF_TURN);
    s = qr * qj - qi * qk;
    a = one + 2 * s;
    b = one - 2 * s;
    // Negative root arguments clamp to zero.
    if (a < 0) a = 0;
    if (b < 0) b = 0;
    r = atan2_angle(int_sqrt(a <<< 16), int_sqrt(b <<< 16));
    if (r < 0) r = 0;
    if (r > QUARTER_TURN) r = QUARTER_TURN;
    roll = angle_to_radians(2 * r - QUARTER_TURN, QUARTER_TURN);
    yaw = angle_to_radians(atan2_angle(2 * (qr * qk + qi * qj),
                                       one - 2 * (qj * qj + qk * qk)), HALF_TURN);
    res = '0;
    res[15:0] = pitch[15:0];
    res[30:16] = roll[14:0];
    res[46:31] = yaw[15:0];
    return res;
  endfunction

  function automatic logic [63:0] pack_quat(int qi, int qj, int qk, int qr);
    return {qr[15:0], qk[15:0], qj[15:0], qi[15:0]};
  endfunction

  // Random component: mostly near a unit quaternion, sometimes full range.
  function automatic int rand_comp(bit wide);
    if (wide) return $urandom_range(65535) - 32768;
    return $urandom_range(32768) - 16384;
  endfunction

  // Driver: presents the next pending quaternion, with random idle bursts.
  int drive_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (drive_gap > 0) begin
        drive_gap <= drive_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        in_tdata <= pending_quats[0];
        expected_angles.push_back(euler_from_quat(pending_quats[0]));
        void'(pending_quats.pop_front());
        in_tvalid <= 1'b1;
        if (!quiet_phase && $urandom_range(7) == 0) drive_gap <= $urandom_range(3, 1);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver stall once the stimulus asks for it.
  initial begin
    wait (hold_start);
    hold_off = 1;
    repeat (150) @(posedge clk);
    hold_off = 0;
  end

  // Monitor: compares each accepted result beat with the oldest expectation and
  // stalls the result side at random, or for one long stretch.
  int stall_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_angles.size() == 0) begin
          $display("%0t unexpected beat: expected none, actual %h", $time, out_tdata);
          errors = errors + 1;
        end else begin
          if (out_tdata[15:0] !== expected_angles[0][15:0]) begin
            $display("%0t pitch mismatch: expected %h, actual %h", $time,
                     expected_angles[0][15:0], out_tdata[15:0]);
            errors = errors + 1;
          end
          if (out_tdata[30:16] !== expected_angles[0][30:16]) begin
            $display("%0t roll mismatch: expected %h, actual %h", $time,
                     expected_angles[0][30:16], out_tdata[30:16]);
            errors = errors + 1;
          end
          if (out_tdata[47:31] !== expected_angles[0][47:31]) begin
            $display("%0t yaw mismatch: expected %h, actual %h", $time,
                     expected_angles[0][47:31], out_tdata[47:31]);
            errors = errors + 1;
          end
          void'(expected_angles.pop_front());
        end
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (stall_gap > 0) begin
        stall_gap <= stall_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!quiet_phase && $urandom_range(7) == 0) stall_gap <= $urandom_range(3, 1);
      end
    end
  end

  // Stimulus: directed corners first, then random beats in three phases.
  initial begin
    int qi, qj, qk, qr;
    int corner[6];
    corner = '{-32768, -16384, -1, 0, 16384, 32767};
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    pending_quats.push_back(pack_quat(0, 0, 0, 0));          // all-zero quaternion
    pending_quats.push_back(pack_quat(0, 0, 0, 16384));      // identity
    pending_quats.push_back(pack_quat(16384, 0, 0, 0));      // pitch on negative x axis
    pending_quats.push_back(pack_quat(0, 0, 16384, 0));      // yaw on negative x axis
    pending_quats.push_back(pack_quat(0, 11585, 0, 11585));  // roll at +pi/2
    pending_quats.push_back(pack_quat(0, -11585, 0, 11585)); // roll at -pi/2
    pending_quats.push_back(pack_quat(0, 32767, 0, 32767));  // negative root argument
    pending_quats.push_back(pack_quat(-32768, 32767, -32768, 32767));
    pending_quats.push_back(pack_quat(32767, 32767, 32767, 32767));
    pending_quats.push_back(pack_quat(-32768, -32768, -32768, -32768));
    for (int n = 0; n < 12; n++)
      pending_quats.push_back(pack_quat(corner[n % 6], corner[(n + 1) % 6],
                                        corner[(n + 3) % 6], corner[(n * 5) % 6]));
    for (int n = 0; n < 900; n++) begin
      qi = rand_comp($urandom_range(3) == 0);
      qj = rand_comp($urandom_range(3) == 0);
      qk = rand_comp($urandom_range(3) == 0);
      qr = rand_comp($urandom_range(3) == 0);
      pending_quats.push_back(pack_quat(qi, qj, qk, qr));
      if (n == 300) begin
        // Long receiver stall while the sender keeps offering beats.
        wait (pending_quats.size() < 200);
        hold_start = 1;
      end
    end
    wait (pending_quats.size() < 150);
    quiet_phase = 1;
    wait (pending_quats.size() == 0 && !in_tvalid);
    wait (expected_angles.size() == 0);
    repeat (STAGES + 40) @(posedge clk);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
